// ===== rtl/spc_pkg.sv =====
// Shared types, constants and encodings of the sprite priority compositor.
package spc_pkg;

	localparam int SPRITES = 90;
	localparam int COLUMNS = 25;
	localparam int ROWS    = 120;

	localparam int IDX_W   = (SPRITES > 1) ? $clog2(SPRITES) : 1;
	localparam int COL_W   = 8;
	localparam int ROW_W   = 12;
	localparam int PIX_W   = 12;
	localparam int CMP_W   = 22;

	localparam int DIV_SHIFT = 24;
	localparam int RECIP_W   = 24;
	localparam int RECIP     = ((1 << DIV_SHIFT) + COLUMNS - 1) / COLUMNS;
	localparam int PROD_W    = PIX_W + RECIP_W;
	localparam int RP_W      = ROW_W + 9;

	localparam logic signed [17:0] X_LIM = 18'(COLUMNS * 256);
	localparam logic signed [17:0] Y_LIM = 18'(ROWS * 256);

	localparam logic [7:0] LVL_C5 = 8'd128;
	localparam logic [7:0] LVL_C4 = 8'd255;
	localparam logic [7:0] LVL_C3 = 8'd192;
	localparam logic [7:0] LVL_C2 = 8'd128;
	localparam logic [7:0] LVL_C1 = 8'd64;
	localparam logic [7:0] LVL_OFF = 8'd0;
	localparam logic [7:0] BLINK_EXPIRED = 8'hFF;

	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 24;

	localparam int OFS_IDX    = 0;
	localparam int OFS_POS_X  = 7;
	localparam int OFS_POS_Y  = 23;
	localparam int OFS_WIDTH  = 39;
	localparam int OFS_HEIGHT = 43;
	localparam int OFS_DEPTH  = 48;
	localparam int OFS_COLOR  = 55;
	localparam int OFS_VEL_X  = 79;
	localparam int OFS_VEL_Y  = 95;
	localparam int OFS_PIXEL  = 111;
	localparam int OFS_RELOAD = 123;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_FRAME = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_MOVE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_FRAME,
		ST_DIV_MUL,
		ST_DIV_ROW,
		ST_DIV_COL,
		ST_SCAN,
		ST_SCAN_END,
		ST_RESULT,
		ST_MOVE,
		ST_MOVE_END
	} state_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [3:0]  width;
		logic [4:0]  height;
		logic [6:0]  depth;
		logic [23:0] color;
		logic [15:0] vel_x;
		logic [15:0] vel_y;
	} sprite_t;

	typedef struct packed {
		logic             capture;
		logic             sprite_wr;
		logic             frame_step;
		logic             div_mul;
		logic             div_row;
		logic             div_col;
		logic             clr_best;
		logic             rd_en;
		logic             rd_scan;
		logic [IDX_W-1:0] rd_addr;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/sprite_priority_compositor_unit.sv =====
// Top level of the sprite priority compositor: controller, datapath and sprite table.
//
//  Channel  Dir  Payload                                         Notes
//  s_axis   in   tuser: req_type; tdata: sprite and query fields  taken only when idle
//  m_axis   out  tuser: sprite_hit; tdata: red, green, blue       one transaction per query
//
// A frame end move and a pixel query each make one table read per sprite through the
// single read port of the sprite table.
// Reset clears the controller, the blink counter and background level; the table is
// undefined until written. A stalled result holds in the output register while the
// next transaction is taken; a query finishing behind it waits for that register.
module sprite_priority_compositor_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// req_type[1:0]
	input  logic [1:0]                    s_tuser,
	// sprite_index[6:0], pos_x[22:7], pos_y[38:23], width[42:39], height[47:43],
	// depth_z[54:48], color[78:55], vel_x[94:79], vel_y[110:95],
	// pixel_index[122:111], blink_reload[130:123], zero fill to 135
	input  logic [spc_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// sprite_hit
	output logic                          m_tuser,
	// red[7:0], green[15:8], blue[23:16]
	output logic [spc_pkg::M_TDATA_W-1:0] m_tdata
);

	import spc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	spc_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

endmodule

// ===== rtl/spc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module spc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/spc_datapath.sv =====
// Datapath: request capture, pixel address split, blink step, sprite scan, motion update and result register.
module spc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spc_pkg::cmd_t                 cmd,
	output spc_pkg::sts_t                 sts,
	input  logic [spc_pkg::S_TDATA_W-1:0] s_tdata,
	output logic [spc_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready
);

	import spc_pkg::*;

	function automatic logic [15:0] bounce_vel(input logic [15:0] pos, input logic [15:0] vel,
			input logic signed [17:0] lim);
		logic signed [17:0] p;
		logic [15:0]        neg;
		p   = {{2{pos[15]}}, pos};
		neg = (vel == 16'h8000) ? 16'h7FFF : 16'(-vel);
		return (p < 18'sd0 || p > lim) ? neg : vel;
	endfunction

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {a[15], a} + {b[15], b};
		if (s[16] != s[15]) begin
			return s[16] ? 16'h8000 : 16'h7FFF;
		end
		return s[15:0];
	endfunction

	logic [6:0]         idx_q;
	sprite_t            entry_q;
	logic [PIX_W-1:0]   pix_q;
	logic [7:0]         reload_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [7:0]         blink_q;
	logic [7:0]         level_q;
	logic [6:0]         best_q;
	logic [23:0]        colr_q;
	logic               hit_q;
	logic               scan_s1;
	logic               move_s1;
	logic [IDX_W-1:0]   addr_s1;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;
	logic               m_tvalid_q;

	sprite_t            rd_entry;
	sprite_t            moved;
	logic               idx_ok;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	sprite_t            wr_data;
	logic [RP_W-1:0]    row_prod;
	logic [PIX_W-1:0]   rem;
	logic [7:0]         blink_src;
	logic [7:0]         level_d;
	logic [15:0]        vx_new;
	logic [15:0]        vy_new;
	logic signed [CMP_W-1:0] cx;
	logic signed [CMP_W-1:0] cy;
	logic signed [CMP_W-1:0] px;
	logic signed [CMP_W-1:0] py;
	logic signed [CMP_W-1:0] xend;
	logic signed [CMP_W-1:0] yend;
	logic               hit_now;

	spc_ram #(
		.WIDTH($bits(sprite_t)),
		.DEPTH(SPRITES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_entry)
	);

	assign idx_ok  = 32'(idx_q) < 32'(SPRITES);
	assign wr_en   = move_s1 || (cmd.sprite_wr && idx_ok);
	assign wr_addr = move_s1 ? addr_s1 : IDX_W'(idx_q);
	assign wr_data = move_s1 ? moved : entry_q;

	always_comb begin
		vx_new         = bounce_vel(rd_entry.pos_x, rd_entry.vel_x, X_LIM);
		vy_new         = bounce_vel(rd_entry.pos_y, rd_entry.vel_y, Y_LIM);
		moved          = rd_entry;
		moved.vel_x    = vx_new;
		moved.vel_y    = vy_new;
		moved.pos_x    = sat_add(rd_entry.pos_x, vx_new);
		moved.pos_y    = sat_add(rd_entry.pos_y, vy_new);
	end

	always_comb begin
		cx      = signed'({{(CMP_W - COL_W - 8){1'b0}}, col_q, 8'b0});
		cy      = signed'({{(CMP_W - ROW_W - 8){1'b0}}, row_q, 8'b0});
		px      = signed'({{(CMP_W - 16){rd_entry.pos_x[15]}}, rd_entry.pos_x});
		py      = signed'({{(CMP_W - 16){rd_entry.pos_y[15]}}, rd_entry.pos_y});
		xend    = px + signed'({{(CMP_W - 12){1'b0}}, rd_entry.width, 8'b0});
		yend    = py + signed'({{(CMP_W - 13){1'b0}}, rd_entry.height, 8'b0});
		hit_now = (cx >= px) && (cx < xend) && (cy >= py) && (cy < yend)
			&& (rd_entry.depth > best_q);
	end

	always_comb begin
		row_prod = RP_W'(row_q) * RP_W'(COLUMNS);
		rem      = pix_q - PIX_W'(row_prod);
	end

	always_comb begin
		blink_src = (blink_q == 8'd0 || blink_q == BLINK_EXPIRED) ? reload_q : blink_q;
		case (blink_q)
			8'd5:    level_d = LVL_C5;
			8'd4:    level_d = LVL_C4;
			8'd3:    level_d = LVL_C3;
			8'd2:    level_d = LVL_C2;
			8'd1:    level_d = LVL_C1;
			default: level_d = LVL_OFF;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q          <= s_tdata[OFS_IDX +: 7];
			entry_q.pos_x  <= s_tdata[OFS_POS_X +: 16];
			entry_q.pos_y  <= s_tdata[OFS_POS_Y +: 16];
			entry_q.width  <= s_tdata[OFS_WIDTH +: 4];
			entry_q.height <= s_tdata[OFS_HEIGHT +: 5];
			entry_q.depth  <= s_tdata[OFS_DEPTH +: 7];
			entry_q.color  <= s_tdata[OFS_COLOR +: 24];
			entry_q.vel_x  <= s_tdata[OFS_VEL_X +: 16];
			entry_q.vel_y  <= s_tdata[OFS_VEL_Y +: 16];
			pix_q          <= s_tdata[OFS_PIXEL +: PIX_W];
			reload_q       <= s_tdata[OFS_RELOAD +: 8];
		end
		if (cmd.div_mul) begin
			prod_q <= PROD_W'(pix_q) * PROD_W'(RECIP);
		end
		if (cmd.div_row) begin
			row_q <= ROW_W'(prod_q >> DIV_SHIFT);
		end
		if (cmd.div_col) begin
			col_q <= row_q[0] ? COL_W'(COLUMNS - 1) - COL_W'(rem) : COL_W'(rem);
		end
		addr_s1 <= cmd.rd_addr;
		if (scan_s1 && hit_now) begin
			colr_q <= rd_entry.color;
		end
		if (cmd.load_out) begin
			m_tdata_q <= hit_q ? {colr_q[7:0], colr_q[15:8], colr_q[23:16]}
				: {level_q, level_q, level_q};
			m_tuser_q <= hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q    <= 8'd0;
			level_q    <= 8'd0;
			best_q     <= 7'd0;
			hit_q      <= 1'b0;
			scan_s1    <= 1'b0;
			move_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			scan_s1 <= cmd.rd_en && cmd.rd_scan;
			move_s1 <= cmd.rd_en && !cmd.rd_scan;
			if (cmd.frame_step) begin
				blink_q <= blink_src - 8'd1;
				level_q <= level_d;
			end
			if (cmd.clr_best) begin
				best_q <= 7'd0;
				hit_q  <= 1'b0;
			end else if (scan_s1 && hit_now) begin
				best_q <= rd_entry.depth;
				hit_q  <= 1'b1;
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tdata      = m_tdata_q;
	assign m_tuser      = m_tuser_q;
	assign m_tvalid     = m_tvalid_q;

endmodule

// ===== rtl/spc_ctrl.sv =====
// Controller: request decode and sequencing of writes, frame steps, pixel split, table scan and motion sweep.
module spc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic [1:0]    s_tuser,
	output logic          s_tready,
	input  spc_pkg::sts_t sts,
	output spc_pkg::cmd_t cmd
);

	import spc_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic             last;

	assign last = idx_q == IDX_W'(SPRITES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		s_tready    = 1'b0;
		cmd         = '0;
		cmd.rd_addr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				idx_d    = '0;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					unique case (req_t'(s_tuser))
						REQ_WRITE: state_d = ST_WRITE;
						REQ_FRAME: state_d = ST_FRAME;
						REQ_QUERY: state_d = ST_DIV_MUL;
						REQ_MOVE:  state_d = ST_MOVE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				cmd.sprite_wr = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_FRAME: begin
				cmd.frame_step = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_DIV_MUL: begin
				cmd.div_mul = 1'b1;
				state_d     = ST_DIV_ROW;
			end
			ST_DIV_ROW: begin
				cmd.div_row = 1'b1;
				state_d     = ST_DIV_COL;
			end
			ST_DIV_COL: begin
				cmd.div_col  = 1'b1;
				cmd.clr_best = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_scan = 1'b1;
				if (last) begin
					state_d = ST_SCAN_END;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_MOVE: begin
				cmd.rd_en = 1'b1;
				if (last) begin
					state_d = ST_MOVE_END;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_MOVE_END: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
